[src/iop_pkg.sv]
`default_nettype none
package iop_pkg;

  // coordinate width inside each 16-bit slot
  localparam int COORD_WIDTH = 16;
  localparam int SLOT_W      = 16;
  localparam int POINT_W     = 3 * SLOT_W;

  // internal widths
  localparam int DIFF_W  = SLOT_W + 1;            // point differences
  localparam int MINOR_W = 2 * DIFF_W + 1;        // 2x2 minors
  localparam int DET3_W  = MINOR_W + DIFF_W + 2;  // 3x3 determinants
  localparam int SQ_W    = 2 * DIFF_W;            // squared lengths, unsigned
  localparam int PROD_W  = 96;                    // cofactor products and sum
  localparam int TOL_W   = 32;

  // split points of the wide multiply
  localparam int ML_W = 27;
  localparam int SL_W = 17;
  localparam int PP_W = 46;

  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [MINOR_W-1:0] minor_t;
  typedef logic signed [DET3_W-1:0]  det3_t;
  typedef logic        [SQ_W-1:0]    sq_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef enum logic [1:0] {
    ORIENT_ZERO = 2'd0,
    ORIENT_POS  = 2'd1,
    ORIENT_NEG  = 2'd2
  } orient_e;

  // sign-extended coordinate of one slot
  function automatic diff_t coord(input logic [POINT_W-1:0] p, input int slot);
    logic signed [COORD_WIDTH-1:0] raw;
    raw = p[SLOT_W*slot +: COORD_WIDTH];
    return DIFF_W'(raw);
  endfunction

endpackage
`default_nettype wire

[src/iop_wide_mul.sv]
`default_nettype none
module iop_wide_mul
  import iop_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire det3_t minor_i,
  input  wire sq_t   sq_i,
  output prod_t      prod_o
);

  logic signed [PP_W-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic signed [ML_W:0]              m_lo;
  logic signed [DET3_W-ML_W-1:0]     m_hi;
  logic signed [SL_W:0]              s_lo;
  logic signed [SQ_W-SL_W:0]         s_hi;
  prod_t prod_q;

  // split operands into narrow pieces
  always_comb begin
    m_lo = {1'b0, minor_i[ML_W-1:0]};
    m_hi = minor_i[DET3_W-1:ML_W];
    s_lo = {1'b0, sq_i[SL_W-1:0]};
    s_hi = {1'b0, sq_i[SQ_W-1:SL_W]};
  end

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= PP_W'(m_lo) * PP_W'(s_lo);
      pp_lh_q <= PP_W'(m_lo) * PP_W'(s_hi);
      pp_hl_q <= PP_W'(m_hi) * PP_W'(s_lo);
      pp_hh_q <= PP_W'(m_hi) * PP_W'(s_hi);
    end
  end

  // recombine
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (PROD_W'(pp_hh_q) <<< (ML_W + SL_W)) + (PROD_W'(pp_hl_q) <<< ML_W)
              + (PROD_W'(pp_lh_q) <<< SL_W) + PROD_W'(pp_ll_q);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

[src/insphere_orientation_predicate_core.sv]
`default_nettype none
// channel   | dir | fields
// s_axis    | in  | point_a, point_b, point_c, point_d, query_point
// m_axis    | out | orientation, inside_res
// cfg       | in  | tolerance
//
// seven register stages; one item accepted per cycle while the output is not stalled
// the 54x34 cofactor multiply is split over two stages
// all stages advance together; a stalled output holds the whole pipeline
// reset clears valid bits and the tolerance
module insphere_orientation_predicate_core
  import iop_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // point_a, point_b, point_c, point_d, query_point
  input  wire logic [239:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // orientation[1:0], inside_res[2], zero fill
  output logic [7:0]        m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int NST = 7;

  logic           en;
  logic [NST:1]   v_q;
  logic [TOL_W-1:0] tol_q;

  diff_t od_q [3][3];
  diff_t ed_q [4][3];
  minor_t om_q [3];
  diff_t  or0_q [3];
  minor_t em_q [3][3];
  diff_t  e0_q [3];
  diff_t  e1_q [3];
  sq_t    sq2_q [4];
  det3_t  dt_q [4];
  sq_t    sq3_q [4];
  orient_e or3_q, or4_q, or5_q, or6_q, or7_q;
  prod_t  prod [4];
  prod_t  det_q;
  logic   inside_q;

  assign en            = !v_q[NST] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-1:1], s_axis_tvalid};
    end
  end

  // stage 1: differences
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          od_q[i][k] <= coord(s_axis_tdata[POINT_W*i +: POINT_W], k)
                      - coord(s_axis_tdata[POINT_W*3 +: POINT_W], k);
        end
      end
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          ed_q[i][k] <= coord(s_axis_tdata[POINT_W*i +: POINT_W], k)
                      - coord(s_axis_tdata[POINT_W*4 +: POINT_W], k);
        end
      end
    end
  end

  function automatic minor_t mnr(input diff_t a, input diff_t b,
                                 input diff_t c, input diff_t d);
    return MINOR_W'(a) * MINOR_W'(b) - MINOR_W'(c) * MINOR_W'(d);
  endfunction

  function automatic det3_t dot3(input diff_t r0, input diff_t r1, input diff_t r2,
                                 input minor_t m0, input minor_t m1, input minor_t m2);
    return DET3_W'(r0) * DET3_W'(m0) - DET3_W'(r1) * DET3_W'(m1)
         + DET3_W'(r2) * DET3_W'(m2);
  endfunction

  // stage 2: 2x2 minors and squared lengths
  always_ff @(posedge clk_i) begin
    logic signed [SQ_W:0] s;
    if (en) begin
      om_q[0] <= mnr(od_q[1][1], od_q[2][2], od_q[1][2], od_q[2][1]);
      om_q[1] <= mnr(od_q[1][0], od_q[2][2], od_q[1][2], od_q[2][0]);
      om_q[2] <= mnr(od_q[1][0], od_q[2][1], od_q[1][1], od_q[2][0]);
      or0_q   <= od_q[0];
      // row pairs (2,3), (1,3), (1,2)
      for (int p = 0; p < 3; p++) begin
        em_q[p][0] <= mnr(ed_q[p == 0 ? 2 : 1][1], ed_q[p == 2 ? 2 : 3][2],
                          ed_q[p == 0 ? 2 : 1][2], ed_q[p == 2 ? 2 : 3][1]);
        em_q[p][1] <= mnr(ed_q[p == 0 ? 2 : 1][0], ed_q[p == 2 ? 2 : 3][2],
                          ed_q[p == 0 ? 2 : 1][2], ed_q[p == 2 ? 2 : 3][0]);
        em_q[p][2] <= mnr(ed_q[p == 0 ? 2 : 1][0], ed_q[p == 2 ? 2 : 3][1],
                          ed_q[p == 0 ? 2 : 1][1], ed_q[p == 2 ? 2 : 3][0]);
      end
      e0_q <= ed_q[0];
      e1_q <= ed_q[1];
      for (int i = 0; i < 4; i++) begin
        s = (SQ_W+1)'(ed_q[i][0]) * (SQ_W+1)'(ed_q[i][0])
          + (SQ_W+1)'(ed_q[i][1]) * (SQ_W+1)'(ed_q[i][1])
          + (SQ_W+1)'(ed_q[i][2]) * (SQ_W+1)'(ed_q[i][2]);
        sq2_q[i] <= s[SQ_W-1:0];
      end
    end
  end

  // stage 3: 3x3 determinants and orientation sign
  always_ff @(posedge clk_i) begin
    det3_t o;
    if (en) begin
      o = dot3(or0_q[0], or0_q[1], or0_q[2], om_q[0], om_q[1], om_q[2]);
      if (o == '0) begin
        or3_q <= ORIENT_ZERO;
      end else if (o[DET3_W-1]) begin
        or3_q <= ORIENT_NEG;
      end else begin
        or3_q <= ORIENT_POS;
      end
      dt_q[0] <= dot3(e1_q[0], e1_q[1], e1_q[2], em_q[0][0], em_q[0][1], em_q[0][2]);
      dt_q[1] <= dot3(e0_q[0], e0_q[1], e0_q[2], em_q[0][0], em_q[0][1], em_q[0][2]);
      dt_q[2] <= dot3(e0_q[0], e0_q[1], e0_q[2], em_q[1][0], em_q[1][1], em_q[1][2]);
      dt_q[3] <= dot3(e0_q[0], e0_q[1], e0_q[2], em_q[2][0], em_q[2][1], em_q[2][2]);
      sq3_q   <= sq2_q;
    end
  end

  // stages 4 and 5: cofactor products
  for (genvar g = 0; g < 4; g++) begin : g_mul
    iop_wide_mul u_mul (
      .clk_i   (clk_i),
      .en_i    (en),
      .minor_i (dt_q[g]),
      .sq_i    (sq3_q[g]),
      .prod_o  (prod[g])
    );
  end

  // stage 6: signed sum of cofactor terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      or4_q <= or3_q;
      or5_q <= or4_q;
      or6_q <= or5_q;
      det_q <= prod[1] - prod[0] + prod[3] - prod[2];
    end
  end

  // stage 7: tolerance compare, output register
  always_ff @(posedge clk_i) begin
    logic signed [PROD_W:0] t;
    if (en) begin
      or7_q <= or6_q;
      if (or6_q == ORIENT_POS) begin
        t = (PROD_W+1)'(det_q) - (PROD_W+1)'({1'b0, tol_q});
        inside_q <= !t[PROD_W] && (t != '0);
      end else begin
        t = (PROD_W+1)'(det_q) + (PROD_W+1)'({1'b0, tol_q});
        inside_q <= t[PROD_W];
      end
    end
  end

  assign m_axis_tvalid = v_q[NST];
  assign m_axis_tdata  = {5'b0, inside_q, or7_q};

  // checks
  a_ready_follows_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");
  a_orient_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("orientation code out of range");
  a_valid_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[3]) |=> v_q[4])
    else $error("item lost in the multiply stages");
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[1])
    else $error("accepted transfer not in first stage");

endmodule
`default_nettype wire
